@@ src/prf_pkg.sv @@
// Shared constants, opcodes and the item packet type for the PC range hit profiler.
`default_nettype none
package prf_pkg;

  localparam int MAX_RANGES = 256;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int MATCH_W    = 8;
  localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);

  localparam logic [ADDR_W-1:0] STEP_BACK = ADDR_W'(4);

  localparam logic [1:0] OP_LOAD_START = 2'd0;
  localparam logic [1:0] OP_LOAD_SIZE  = 2'd1;
  localparam logic [1:0] OP_TRACE      = 2'd2;
  localparam logic [1:0] OP_READ       = 2'd3;

  typedef struct packed {
    logic               act;
    logic [1:0]         op;
    logic [ADDR_W-1:0]  addr;
    logic [IDX_W-1:0]   idx;
    logic               wr_lo;
    logic               wr_hi;
    logic [IDX_W-1:0]   hi_idx;
    logic [ADDR_W-1:0]  hi_val;
    logic               done;
    logic [COUNT_W-1:0] count;
    logic [MATCH_W-1:0] match;
    logic               hit;
    logic               err;
  } prf_pkt_t;

endpackage
`default_nettype wire

@@ src/prf_cell.sv @@
// One table entry of the profiler chain: range bounds, hit counter and packet stage.
`default_nettype none
module prf_cell import prf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire prf_pkt_t         pkt_i,
  output prf_pkt_t              pkt_o
);

  logic [ADDR_W-1:0]  low_r;
  logic [ADDR_W-1:0]  high_r;
  logic [COUNT_W-1:0] hits_r;
  logic               valid_r;
  prf_pkt_t           pkt_r;
  prf_pkt_t           pkt_nxt;
  logic               trace_hit;
  logic               live;

  assign live      = pkt_i.act && !pkt_i.done;
  assign trace_hit = live && (pkt_i.op == OP_TRACE) && valid_r &&
                     (pkt_i.addr >= low_r) && (pkt_i.addr <= high_r);

  always_comb begin
    pkt_nxt = pkt_i;
    if (trace_hit) begin
      pkt_nxt.done  = 1'b1;
      pkt_nxt.hit   = 1'b1;
      pkt_nxt.match = MATCH_W'(cell_idx);
    end else if (live && (pkt_i.op == OP_READ) && (pkt_i.idx == cell_idx)) begin
      pkt_nxt.done  = 1'b1;
      pkt_nxt.count = hits_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && pkt_i.act && pkt_i.wr_lo && (pkt_i.idx == cell_idx)) begin
      low_r <= pkt_i.addr;
    end
    if (en && pkt_i.act && pkt_i.wr_hi && (pkt_i.hi_idx == cell_idx)) begin
      high_r <= pkt_i.hi_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      hits_r    <= '0;
      pkt_r.act <= 1'b0;
    end else if (en) begin
      if (pkt_i.act && pkt_i.wr_lo && (pkt_i.idx == cell_idx)) begin
        valid_r <= 1'b1;
      end
      if (trace_hit && (hits_r != {COUNT_W{1'b1}})) begin
        hits_r <= hits_r + COUNT_W'(1);
      end
      pkt_r <= pkt_nxt;
    end
  end

  assign pkt_o = pkt_r;

endmodule
`default_nettype wire

@@ src/prf_ctrl.sv @@
// Issue logic: entry count, first start address and packet build for the chain head.
`default_nettype none
module prf_ctrl import prf_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [1:0]        in_opcode,
  input  wire logic [ADDR_W-1:0] in_address_value,
  input  wire logic [7:0]        in_entry_index,
  output prf_pkt_t               pkt_o
);

  logic [CNT_W-1:0]  loaded_r;
  logic [CNT_W-1:0]  loaded_nxt;
  logic [ADDR_W-1:0] first_low_r;
  logic [ADDR_W-1:0] first_low_nxt;
  logic              accept;
  logic              full;
  prf_pkt_t          pkt;

  assign accept = in_valid && in_ready;
  assign full   = (loaded_r >= CNT_W'(MAX_RANGES));

  always_comb begin
    pkt      = '0;
    pkt.act  = accept;
    pkt.op   = in_opcode;
    pkt.addr = in_address_value;
    case (in_opcode)
      OP_LOAD_START: begin
        if (full) begin
          pkt.err  = 1'b1;
          pkt.done = 1'b1;
        end else begin
          pkt.wr_lo = 1'b1;
          pkt.idx   = IDX_W'(loaded_r);
          if (loaded_r != '0) begin
            pkt.wr_hi  = 1'b1;
            pkt.hi_idx = IDX_W'(loaded_r - CNT_W'(1));
            pkt.hi_val = in_address_value - STEP_BACK;
          end
        end
      end
      OP_LOAD_SIZE: begin
        if (loaded_r == '0) begin
          pkt.err  = 1'b1;
          pkt.done = 1'b1;
        end else begin
          pkt.wr_hi  = 1'b1;
          pkt.hi_idx = IDX_W'(loaded_r - CNT_W'(1));
          pkt.hi_val = first_low_r + in_address_value;
        end
      end
      OP_READ: begin
        pkt.idx = IDX_W'(in_entry_index);
        if (32'(in_entry_index) >= 32'(loaded_r)) begin
          pkt.err  = 1'b1;
          pkt.done = 1'b1;
        end
      end
      default: begin
        pkt.done = 1'b0;
      end
    endcase
  end

  always_comb begin
    loaded_nxt    = loaded_r;
    first_low_nxt = first_low_r;
    if (accept && (in_opcode == OP_LOAD_START) && !full) begin
      loaded_nxt = loaded_r + CNT_W'(1);
      if (loaded_r == '0) begin
        first_low_nxt = in_address_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
    end else begin
      loaded_r <= loaded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_low_r <= first_low_nxt;
  end

  assign pkt_o = pkt;

endmodule
`default_nettype wire

@@ src/pc_range_hit_profiler_top.sv @@
// Top level of the PC range hit profiler: issue logic and a row of range cells.
//
//   channel | direction | ports
//   in      | input     | in_valid, in_ready, in_opcode, in_address_value, in_entry_index
//   out     | output    | out_valid, out_ready, out_hit_count, out_matched_index,
//           |           | out_hit, out_error
//
// Takes one item per cycle while no result is held; each result leaves once its packet has
// passed the register of every table cell, moving one cell per cycle down the row.
// Reset clears entry count, valid bits and hit counters at once; no clearing pass.
// A held result stalls the whole row and in_ready drops with it.
`default_nettype none
module pc_range_hit_profiler_top import prf_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [ADDR_W-1:0]  in_address_value,
  input  wire logic [7:0]         in_entry_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [COUNT_W-1:0]      out_hit_count,
  output logic [MATCH_W-1:0]      out_matched_index,
  output logic                    out_hit,
  output logic                    out_error
);

  prf_pkt_t chain_pkt [MAX_RANGES+1];
  logic     advance;

  assign advance  = !chain_pkt[MAX_RANGES].act || out_ready;
  assign in_ready = advance;

  prf_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_address_value (in_address_value),
    .in_entry_index   (in_entry_index),
    .pkt_o            (chain_pkt[0])
  );

  for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
    prf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (advance),
      .cell_idx (IDX_W'(g)),
      .pkt_i    (chain_pkt[g]),
      .pkt_o    (chain_pkt[g+1])
    );
  end

  assign out_valid         = chain_pkt[MAX_RANGES].act;
  assign out_hit_count     = chain_pkt[MAX_RANGES].count;
  assign out_matched_index = chain_pkt[MAX_RANGES].match;
  assign out_hit           = chain_pkt[MAX_RANGES].hit;
  assign out_error         = chain_pkt[MAX_RANGES].err;

endmodule
`default_nettype wire

@@ src/prf_checker.sv @@
// Port checker for the PC range hit profiler and its bind to the top level.
`default_nettype none
module prf_checker import prf_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [COUNT_W-1:0] out_hit_count,
  input wire logic [MATCH_W-1:0] out_matched_index,
  input wire logic               out_hit,
  input wire logic               out_error
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_hit_count))
    else $error("hit count changed while stalled");

  a_hit_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> !out_error)
    else $error("hit and error together");

  a_count_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_hit_count != '0) |-> !out_hit && !out_error)
    else $error("nonzero count on a non-read result");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_matched_index == '0)
    else $error("matched index set without a hit");

endmodule

bind pc_range_hit_profiler_top prf_checker u_prf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_hit_count     (out_hit_count),
  .out_matched_index (out_matched_index),
  .out_hit           (out_hit),
  .out_error         (out_error)
);
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the PC range hit profiler: directed and random items, scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import prf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = MAX_RANGES + 64;
  localparam int MAX_PRINTS   = 40;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [1:0]        op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        idx;
    logic              drain;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MATCH_W-1:0] match;
    logic               hit;
    logic               err;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = OP_LOAD_START;
  logic [ADDR_W-1:0]  in_address_value = '0;
  logic [7:0]         in_entry_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COUNT_W-1:0] out_hit_count;
  logic [MATCH_W-1:0] out_matched_index;
  logic               out_hit;
  logic               out_error;

  item_t   profiler_items[$];
  result_t awaited_results[$];

  logic [ADDR_W-1:0]  tbl_low  [MAX_RANGES];
  logic [ADDR_W-1:0]  tbl_high [MAX_RANGES];
  logic [COUNT_W-1:0] tbl_hits [MAX_RANGES];
  int unsigned        tbl_used;

  logic [ADDR_W-1:0] gen_low [MAX_RANGES];
  int unsigned       gen_used;
  logic              gen_closed;
  logic [ADDR_W-1:0] gen_next;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  pc_range_hit_profiler_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_address_value  (in_address_value),
    .in_entry_index    (in_entry_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_hit_count     (out_hit_count),
    .out_matched_index (out_matched_index),
    .out_hit           (out_hit),
    .out_error         (out_error)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what);
    fail_count++;
    if (fail_count <= MAX_PRINTS) $display("%0t: %s", $time, what);
  endtask

  function automatic result_t tally_item(input item_t it);
    result_t r;
    logic    found;
    int      n;
    r = '0;
    found = 1'b0;
    case (it.op)
      OP_LOAD_START: begin
        if (tbl_used >= MAX_RANGES) begin
          r.err = 1'b1;
        end else begin
          tbl_low[tbl_used] = it.addr;
          if (tbl_used > 0) tbl_high[tbl_used-1] = it.addr - STEP_BACK;
          tbl_used++;
        end
      end
      OP_LOAD_SIZE: begin
        if (tbl_used == 0) r.err = 1'b1;
        else tbl_high[tbl_used-1] = tbl_low[0] + it.addr;
      end
      OP_TRACE: begin
        for (n = 0; n < tbl_used; n++) begin
          if (!found && it.addr >= tbl_low[n] && it.addr <= tbl_high[n]) begin
            found = 1'b1;
            if (tbl_hits[n] != '1) tbl_hits[n] = tbl_hits[n] + 1'b1;
            r.hit = 1'b1;
            r.match = MATCH_W'(n);
          end
        end
      end
      OP_READ: begin
        if (it.idx < tbl_used) r.count = tbl_hits[it.idx];
        else r.err = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] closing_size();
    if (gen_used == 0 || $urandom_range(0, 9) == 0) return $urandom;
    return gen_low[gen_used-1] + ADDR_W'(4 * $urandom_range(0, 16'h4000)) - gen_low[0];
  endfunction

  function automatic logic [ADDR_W-1:0] next_start();
    logic [ADDR_W-1:0] a;
    if ($urandom_range(0, 6) == 0) return $urandom;
    a = gen_next;
    gen_next = gen_next + ADDR_W'(4 * $urandom_range(1, 32'h40000));
    return a;
  endfunction

  function automatic logic [ADDR_W-1:0] trace_pc();
    logic [ADDR_W-1:0] base;
    if (gen_used == 0 || $urandom_range(0, 6) == 0) return $urandom;
    base = gen_low[$urandom_range(0, gen_used - 1)];
    case ($urandom_range(0, 4))
      0: return base;
      1: return base - 1'b1;
      2: return base - STEP_BACK;
      default: return base + ADDR_W'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [7:0] read_index();
    if (gen_used == 0 || $urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, gen_used - 1));
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic [7:0] idx, input logic drain);
    item_t it;
    logic  wait_first;
    wait_first = drain;
    if (op == OP_TRACE && gen_used > 0 && !gen_closed) begin
      it.op = OP_LOAD_SIZE;
      it.addr = closing_size();
      it.idx = 8'($urandom);
      it.drain = wait_first;
      profiler_items = {profiler_items, it};
      gen_closed = 1'b1;
      wait_first = 1'b0;
    end
    it.op = op;
    it.addr = addr;
    it.idx = idx;
    it.drain = wait_first;
    profiler_items = {profiler_items, it};
    case (op)
      OP_LOAD_START: begin
        if (gen_used < MAX_RANGES) begin
          gen_low[gen_used] = addr;
          gen_used++;
          gen_closed = 1'b0;
        end
      end
      OP_LOAD_SIZE: begin
        if (gen_used > 0) gen_closed = 1'b1;
      end
      default: ;
    endcase
  endtask

  item_t       cur_item;
  int unsigned send_gap;
  int unsigned send_calm;
  logic        send_hold;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= OP_LOAD_START;
      in_address_value <= '0;
      in_entry_index <= '0;
      send_gap = 0;
      send_calm = 0;
    end else begin
      send_hold = in_valid;
      if (in_valid && in_ready) begin
        awaited_results = {awaited_results, tally_item(cur_item)};
        send_hold = 1'b0;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = $urandom_range(0, 11);
          if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(16, 64);
        end
      end
      if (!send_hold) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (profiler_items.size() != 0 &&
                     !(profiler_items[0].drain && awaited_results.size() != 0)) begin
          cur_item = profiler_items.pop_front();
          in_opcode <= cur_item.op;
          in_address_value <= cur_item.addr;
          in_entry_index <= cur_item.idx;
          send_hold = 1'b1;
        end
      end
      in_valid <= send_hold;
    end
  end

  int unsigned take_stall;
  int unsigned take_calm;
  logic        take_hold;
  result_t     awaited;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      take_stall = 0;
      take_calm = 0;
    end else begin
      take_hold = out_ready;
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no item awaiting it");
        end else begin
          awaited = awaited_results.pop_front();
          if (out_hit_count !== awaited.count)
            report_mismatch($sformatf("hit_count got %0h expected %0h",
                                      out_hit_count, awaited.count));
          if (out_matched_index !== awaited.match)
            report_mismatch($sformatf("matched_index got %0d expected %0d",
                                      out_matched_index, awaited.match));
          if (out_hit !== awaited.hit)
            report_mismatch($sformatf("hit got %b expected %b", out_hit, awaited.hit));
          if (out_error !== awaited.err)
            report_mismatch($sformatf("error got %b expected %b", out_error, awaited.err));
        end
        if (take_calm > 0) begin
          take_calm--;
          take_stall = 0;
        end else begin
          take_stall = $urandom_range(0, 11);
          if ($urandom_range(0, 15) == 0) take_calm = $urandom_range(16, 64);
        end
        take_hold = (take_stall == 0);
      end else if (!out_ready) begin
        if (take_stall > 0) take_stall--;
        take_hold = (take_stall == 0);
      end
      out_ready <= take_hold;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    int          k;
    int unsigned pick;
    logic [1:0]  op;
    for (k = 0; k < MAX_RANGES; k++) begin
      tbl_low[k] = '0;
      tbl_high[k] = '0;
      tbl_hits[k] = '0;
      gen_low[k] = '0;
    end
    tbl_used = 0;
    gen_used = 0;
    gen_closed = 1'b0;
    gen_next = $urandom & 32'h7FFF_FFFC;

    queue_item(OP_READ,       32'h0000_0000, 8'd0,   1'b0);
    queue_item(OP_LOAD_SIZE,  32'h0000_0100, 8'hFF,  1'b0);
    queue_item(OP_TRACE,      32'h0000_1000, 8'h00,  1'b0);
    queue_item(OP_LOAD_START, 32'h0000_1000, 8'h5A,  1'b0);
    queue_item(OP_LOAD_SIZE,  32'h0000_0100, 8'hA5,  1'b0);
    queue_item(OP_TRACE,      32'h0000_1000, 8'h00,  1'b0);
    queue_item(OP_TRACE,      32'h0000_1100, 8'h00,  1'b0);
    queue_item(OP_TRACE,      32'h0000_1104, 8'h00,  1'b0);
    queue_item(OP_TRACE,      32'h0000_0FFF, 8'h00,  1'b0);
    queue_item(OP_LOAD_SIZE,  32'h0000_0200, 8'h00,  1'b0);
    queue_item(OP_TRACE,      32'h0000_1200, 8'h00,  1'b0);
    queue_item(OP_LOAD_START, 32'h0000_2000, 8'h00,  1'b0);
    queue_item(OP_LOAD_SIZE,  32'hFFFF_F000, 8'h00,  1'b0);
    queue_item(OP_TRACE,      32'h0000_2000, 8'h00,  1'b0);
    queue_item(OP_LOAD_SIZE,  32'hFFFF_EFFF, 8'h00,  1'b0);
    queue_item(OP_TRACE,      32'hFFFF_FFFF, 8'hFF,  1'b0);
    queue_item(OP_TRACE,      32'h0000_1FFC, 8'h00,  1'b0);
    queue_item(OP_LOAD_START, 32'h0000_0000, 8'h00,  1'b0);
    queue_item(OP_LOAD_SIZE,  32'h0000_0000, 8'h00,  1'b0);
    queue_item(OP_TRACE,      32'h0000_0000, 8'h00,  1'b0);
    queue_item(OP_TRACE,      32'h0000_1000, 8'h00,  1'b0);
    queue_item(OP_READ,       32'hFFFF_FFFF, 8'd0,   1'b0);
    queue_item(OP_READ,       32'h0000_0000, 8'd2,   1'b0);
    queue_item(OP_READ,       32'h0000_0000, 8'd3,   1'b0);
    queue_item(OP_READ,       32'h0000_0000, 8'd255, 1'b0);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) op = (gen_used < MAX_RANGES || pick < 2) ? OP_LOAD_START : OP_TRACE;
      else if (pick < 35) op = OP_LOAD_SIZE;
      else if (pick < 80) op = OP_TRACE;
      else op = OP_READ;
      case (op)
        OP_LOAD_START: queue_item(op, next_start(), 8'($urandom), k == RANDOM_ITEMS / 2);
        OP_LOAD_SIZE:  queue_item(op, closing_size(), 8'($urandom), k == RANDOM_ITEMS / 2);
        OP_TRACE:      queue_item(op, trace_pc(), 8'($urandom), k == RANDOM_ITEMS / 2);
        default:       queue_item(op, $urandom, read_index(), k == RANDOM_ITEMS / 2);
      endcase
    end

    while (gen_used < MAX_RANGES) queue_item(OP_LOAD_START, next_start(), 8'($urandom), 1'b0);
    queue_item(OP_LOAD_START, next_start(), 8'hA5, 1'b1);
    queue_item(OP_LOAD_START, 32'hFFFF_FFFC, 8'h5A, 1'b0);
    queue_item(OP_LOAD_SIZE, closing_size(), 8'h00, 1'b0);
    for (k = 0; k < 12; k++) queue_item(OP_TRACE, trace_pc(), 8'($urandom), 1'b0);
    queue_item(OP_READ, 32'h0, 8'd255, 1'b0);
    queue_item(OP_READ, 32'h0, 8'd0, 1'b0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (profiler_items.size() != 0 || in_valid || awaited_results.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
